@@ rtl/psm_pkg.sv @@
// shared types and constants of the partitioned multi-stack block
package psm_pkg;

  // fixed field widths
  localparam int CmdW     = 2;
  localparam int SelW     = 2;
  localparam int ValueW   = 32;
  localparam int StatusW  = 3;
  localparam int WordsW   = 5;
  localparam int StacksW  = 3;
  localparam int CountW   = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;
  // address field wide enough for the deepest memory supported
  localparam int AddrMaxW = 12;

  // queue depths between the parts
  localparam int MidDepth = 2;
  localparam int OutDepth = 4;
  localparam int OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CmdPush = 2'd0,
    CmdPop  = 2'd1,
    CmdDump = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StPushed    = 3'd0,
    StPopped    = 3'd1,
    StOverflow  = 3'd2,
    StUnderflow = 3'd3,
    StEmpty     = 3'd4,
    StDumpElem  = 3'd5,
    StBadStack  = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWordsUsed   = 1'b0,
    CfgStacksInUse = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OpWrite  = 2'd0,
    OpRead   = 2'd1,
    OpDump   = 2'd2,
    OpReport = 2'd3
  } op_kind_e;

  // classified work handed from the front to the back
  typedef struct packed {
    op_kind_e              kind;
    status_e               status;
    logic [AddrMaxW-1:0]   addr;
    logic [ValueW-1:0]     value;
    logic [CountW-1:0]     count;
  } op_t;

  // one result transaction
  typedef struct packed {
    status_e             status;
    logic [ValueW-1:0]   data;
    logic                last;
  } result_t;

endpackage

@@ rtl/psm_fifo.sv @@
// small register queue used between the front, the back and the result port
module psm_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  T                            data_i,
  input  logic                        pop_i,
  output T                            data_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [$clog2(Depth+1)-1:0]  count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  T                slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign count_o = cnt_q;

endmodule

@@ rtl/psm_front.sv @@
// front part: configuration, segment length divider, fill counts, classification
module psm_front #(
  parameter int MEM_DEPTH  = 16,
  parameter int MAX_STACKS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [psm_pkg::CmdW-1:0]      command_i,
  input  logic [psm_pkg::SelW-1:0]      stack_select_i,
  input  logic [psm_pkg::ValueW-1:0]    push_value_i,
  input  logic                          cfg_we_i,
  input  logic [psm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [psm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          mid_full_i,
  output logic                          full_o,
  output logic                          op_valid_o,
  output psm_pkg::op_t                  op_o
);

  // only stacks that a select can reach need a fill count
  localparam int NumStk    = (MAX_STACKS < 4) ? MAX_STACKS : 4;
  localparam int FillIdxW  = (NumStk > 1) ? $clog2(NumStk) : 1;
  localparam int WordsRst  = (MEM_DEPTH < 16) ? MEM_DEPTH : 16;
  localparam int StacksRst = (MAX_STACKS < 4) ? MAX_STACKS : 4;
  localparam int SegRst    = WordsRst / StacksRst;
  localparam int WordsW    = psm_pkg::WordsW;
  localparam int StacksW   = psm_pkg::StacksW;
  localparam int CountW    = psm_pkg::CountW;

  logic [WordsW-1:0]   words_q;
  logic [StacksW-1:0]  stacks_q;
  logic [WordsW-1:0]   words_new;
  logic [StacksW-1:0]  stacks_new;

  // divider: quotient register doubles as the segment length
  logic                div_busy_q;
  logic [2:0]          div_cnt_q;
  logic [StacksW-1:0]  div_rem_q;
  logic [StacksW-1:0]  div_dvs_q;
  logic [WordsW-1:0]   seg_q;
  logic [StacksW:0]    div_trial;
  logic                div_bit;

  logic [CountW-1:0]   fill_q [NumStk];
  logic [FillIdxW-1:0] fidx;
  logic [CountW-1:0]   fill;
  logic                accept;
  logic                bad_stack;
  logic [6:0]          base;
  logic [7:0]          push_addr;
  logic [7:0]          pop_addr;
  logic                push_ok;
  psm_pkg::cmd_e       cmd;

  assign cmd = psm_pkg::cmd_e'(command_i);

  // clamp written register values into their legal ranges
  always_comb begin
    words_new  = cfg_wdata_i;
    stacks_new = cfg_wdata_i[StacksW-1:0];
    if (words_new == '0) begin
      words_new = WordsW'(1);
    end else if (32'(words_new) > MEM_DEPTH) begin
      words_new = WordsW'(MEM_DEPTH);
    end
    if (stacks_new == '0) begin
      stacks_new = StacksW'(1);
    end else if (32'(stacks_new) > MAX_STACKS) begin
      stacks_new = StacksW'(MAX_STACKS);
    end
  end

  // restoring divider step
  assign div_trial = {div_rem_q, seg_q[WordsW-1]};
  assign div_bit   = (div_trial >= {1'b0, div_dvs_q});

  // configuration registers and segment length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q    <= WordsW'(WordsRst);
      stacks_q   <= StacksW'(StacksRst);
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
      div_dvs_q  <= StacksW'(StacksRst);
      seg_q      <= WordsW'(SegRst);
    end else if (cfg_we_i && (cfg_idx_i == psm_pkg::CfgWordsUsed ||
                              cfg_idx_i == psm_pkg::CfgStacksInUse)) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
      if (cfg_idx_i == psm_pkg::CfgWordsUsed) begin
        words_q   <= words_new;
        seg_q     <= words_new;
        div_dvs_q <= stacks_q;
      end else begin
        stacks_q  <= stacks_new;
        seg_q     <= words_q;
        div_dvs_q <= stacks_new;
      end
    end else if (div_busy_q) begin
      div_rem_q <= div_bit ? StacksW'(div_trial - {1'b0, div_dvs_q})
                           : StacksW'(div_trial);
      seg_q     <= {seg_q[WordsW-2:0], div_bit};
      div_cnt_q <= div_cnt_q + 3'd1;
      if (div_cnt_q == 3'(WordsW - 1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  // classification of the incoming transaction
  assign full_o    = div_busy_q || mid_full_i;
  assign accept    = push_i && !full_o;
  assign bad_stack = ({1'b0, stack_select_i} >= stacks_q) ||
                     (32'(stack_select_i) >= MAX_STACKS);
  assign fidx      = bad_stack ? '0 : stack_select_i[FillIdxW-1:0];
  assign fill      = fill_q[fidx];
  assign base      = 7'(stack_select_i) * 7'(seg_q);
  assign push_addr = 8'(base) + 8'(fill);
  assign pop_addr  = 8'(base) + 8'(fill) - 8'd1;
  assign push_ok   = (fill < seg_q) && (32'(push_addr) < MEM_DEPTH);

  always_comb begin
    op_o        = '0;
    op_o.value  = push_value_i;
    op_o.count  = fill;
    op_valid_o  = accept && (cmd != psm_pkg::CmdNone);
    if (bad_stack) begin
      op_o.kind   = psm_pkg::OpReport;
      op_o.status = psm_pkg::StBadStack;
    end else begin
      unique case (cmd)
        psm_pkg::CmdPush: begin
          op_o.addr   = psm_pkg::AddrMaxW'(push_addr);
          op_o.kind   = push_ok ? psm_pkg::OpWrite : psm_pkg::OpReport;
          op_o.status = push_ok ? psm_pkg::StPushed : psm_pkg::StOverflow;
        end
        psm_pkg::CmdPop: begin
          op_o.addr   = psm_pkg::AddrMaxW'(pop_addr);
          op_o.kind   = (fill != '0) ? psm_pkg::OpRead : psm_pkg::OpReport;
          op_o.status = (fill != '0) ? psm_pkg::StPopped : psm_pkg::StUnderflow;
        end
        psm_pkg::CmdDump: begin
          op_o.addr   = psm_pkg::AddrMaxW'(base);
          op_o.kind   = (fill != '0) ? psm_pkg::OpDump : psm_pkg::OpReport;
          op_o.status = (fill != '0) ? psm_pkg::StDumpElem : psm_pkg::StEmpty;
        end
        default: begin
          op_o.kind   = psm_pkg::OpReport;
          op_o.status = psm_pkg::StBadStack;
        end
      endcase
    end
  end

  // fill counts, cleared on any repartition
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStk; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i == psm_pkg::CfgWordsUsed ||
                              cfg_idx_i == psm_pkg::CfgStacksInUse)) begin
      for (int i = 0; i < NumStk; i++) begin
        fill_q[i] <= '0;
      end
    end else if (op_valid_o && op_o.kind == psm_pkg::OpWrite) begin
      fill_q[fidx] <= fill + CountW'(1);
    end else if (op_valid_o && op_o.kind == psm_pkg::OpRead) begin
      fill_q[fidx] <= fill - CountW'(1);
    end
  end

endmodule

@@ rtl/psm_back.sv @@
// back part: stack memory, dump sequencing and result staging
module psm_back #(
  parameter int MEM_DEPTH  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mid_empty_i,
  input  psm_pkg::op_t                 op_i,
  output logic                         mid_pop_o,
  input  logic [psm_pkg::OutCntW-1:0]  out_count_i,
  output logic                         res_valid_o,
  output psm_pkg::result_t             res_o
);

  localparam int AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int WordW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int CountW = psm_pkg::CountW;

  logic [WordW-1:0]   mem_q [MEM_DEPTH];
  logic [WordW-1:0]   rdata_q;

  logic               dump_busy_q;
  logic [AW-1:0]      dump_addr_q;
  logic [CountW-1:0]  dump_left_q;

  logic               resp_valid_q;
  logic               resp_rd_q;
  psm_pkg::result_t   resp_q;

  logic               room;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      op_addr;
  logic [AW-1:0]      rd_addr;
  logic               issue;
  logic               resp_rd_d;
  psm_pkg::result_t   resp_d;

  // issue only if the result queue can take everything in flight
  assign room      = (32'(out_count_i) + 32'(resp_valid_q)) < psm_pkg::OutDepth;
  assign mid_pop_o = room && !dump_busy_q && !mid_empty_i;
  assign issue     = room && (dump_busy_q || !mid_empty_i);
  assign op_addr   = AW'(op_i.addr);

  // decode of the transaction being carried out this cycle
  always_comb begin
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = op_addr;
    resp_rd_d   = 1'b0;
    resp_d      = '0;
    resp_d.last = 1'b1;
    if (dump_busy_q) begin
      rd_en         = 1'b1;
      rd_addr       = dump_addr_q;
      resp_rd_d     = 1'b1;
      resp_d.status = psm_pkg::StDumpElem;
      resp_d.last   = (dump_left_q == CountW'(1));
    end else begin
      resp_d.status = op_i.status;
      unique case (op_i.kind)
        psm_pkg::OpWrite: begin
          wr_en       = 1'b1;
          resp_d.data = psm_pkg::ValueW'(op_i.value[WordW-1:0]);
        end
        psm_pkg::OpRead: begin
          rd_en     = 1'b1;
          resp_rd_d = 1'b1;
        end
        psm_pkg::OpDump: begin
          rd_en       = 1'b1;
          resp_rd_d   = 1'b1;
          resp_d.last = (op_i.count == CountW'(1));
        end
        default: begin
          resp_d.data = '0;
        end
      endcase
    end
  end

  // dump sequencer and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_busy_q  <= 1'b0;
      dump_addr_q  <= '0;
      dump_left_q  <= '0;
      resp_valid_q <= 1'b0;
      resp_rd_q    <= 1'b0;
      resp_q       <= '0;
    end else begin
      resp_valid_q <= issue;
      if (issue) begin
        resp_rd_q <= resp_rd_d;
        resp_q    <= resp_d;
        if (dump_busy_q) begin
          dump_addr_q <= dump_addr_q + AW'(1);
          dump_left_q <= dump_left_q - CountW'(1);
          if (dump_left_q == CountW'(1)) begin
            dump_busy_q <= 1'b0;
          end
        end else if (op_i.kind == psm_pkg::OpDump && op_i.count != CountW'(1)) begin
          dump_busy_q <= 1'b1;
          dump_addr_q <= op_addr + AW'(1);
          dump_left_q <= op_i.count - CountW'(1);
        end
      end
    end
  end

  // stack memory, one access per cycle
  always_ff @(posedge clk_i) begin
    if (issue && wr_en) begin
      mem_q[op_addr] <= op_i.value[WordW-1:0];
    end
    if (issue && rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // merge read data into the staged result
  always_comb begin
    res_o = resp_q;
    if (resp_rd_q) begin
      res_o.data = psm_pkg::ValueW'(rdata_q);
    end
  end
  assign res_valid_o = resp_valid_q;

endmodule

@@ rtl/partitioned_multi_stack_top.sv @@
// top level of the partitioned multi-stack block
//
// Several stacks share one word memory cut into equal segments. Items come
// in on a queue-style port: a transaction is taken when push is high and
// full is low. Results leave the same way: the oldest result sits on
// status_o/data_value_o/last_o while empty is low and is taken with pop.
// Push, pop and error items give one result each, with last_o high; a dump
// gives one result per stored word, bottom to top, last_o on the final one.
// The first result passes through the middle queue, the back part's result
// stage and the result queue before it shows on the result ports.
// Push, pop and error items sustain one per cycle while full is low and the
// receiver keeps popping; a dump holds the memory port for one read per
// stored word, and new items queue in front of it until the two-entry
// middle queue fills and full rises. A configuration write empties all
// stacks and starts the segment length divide, during which full stays high.
// Reset empties every stack, loads the default configuration and clears
// all queues. When the receiver stops popping, the four-entry result queue
// fills, the back part stops issuing and full rises soon after.
module partitioned_multi_stack_top #(
  parameter int MEM_DEPTH  = 16,
  parameter int MAX_STACKS = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [psm_pkg::CmdW-1:0]             command_i,
  input  logic [psm_pkg::SelW-1:0]             stack_select_i,
  input  logic signed [psm_pkg::ValueW-1:0]    push_value_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [psm_pkg::StatusW-1:0]          status_o,
  output logic signed [psm_pkg::ValueW-1:0]    data_value_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic [psm_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [psm_pkg::CfgDataW-1:0]         cfg_wdata_i
);

  localparam int MidCntW = $clog2(psm_pkg::MidDepth + 1);

  logic                         op_valid;
  psm_pkg::op_t                 op_front;
  psm_pkg::op_t                 op_back;
  logic                         mid_full;
  logic                         mid_empty;
  logic                         mid_pop;
  logic [MidCntW-1:0]           mid_count;
  logic                         res_valid;
  psm_pkg::result_t             res_back;
  psm_pkg::result_t             res_head;
  logic                         out_full;
  logic [psm_pkg::OutCntW-1:0]  out_count;

  psm_front #(
    .MEM_DEPTH  (MEM_DEPTH),
    .MAX_STACKS (MAX_STACKS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .command_i      (command_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mid_full_i     (mid_full),
    .full_o         (full),
    .op_valid_o     (op_valid),
    .op_o           (op_front)
  );

  // queue between classification and execution
  psm_fifo #(
    .T     (psm_pkg::op_t),
    .Depth (psm_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_valid),
    .data_i  (op_front),
    .pop_i   (mid_pop),
    .data_o  (op_back),
    .empty_o (mid_empty),
    .full_o  (mid_full),
    .count_o (mid_count)
  );

  psm_back #(
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty || (mid_count == '0)),
    .op_i        (op_back),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .res_valid_o (res_valid),
    .res_o       (res_back)
  );

  // result queue toward the receiver
  psm_fifo #(
    .T     (psm_pkg::result_t),
    .Depth (psm_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid && !out_full),
    .data_i  (res_back),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty),
    .full_o  (out_full),
    .count_o (out_count)
  );

  assign status_o     = res_head.status;
  assign data_value_o = res_head.data;
  assign last_o       = res_head.last;

endmodule

@@ rtl/psm_checker.sv @@
// port-level checks of the partitioned multi-stack block and their binding
module psm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               full,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [psm_pkg::StatusW-1:0]        status_o,
  input  logic [psm_pkg::ValueW-1:0]         data_value_o,
  input  logic                               last_o,
  input  logic                               cfg_we_i
);

  // no results are held while reset is applied
  a_reset_empty: assert property (@(posedge clk_i) (!rst_ni && $past(!rst_ni)) |-> empty)
    else $error("result queue not empty during reset");

  // a repartition blocks input while the segment length is computed
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> full)
    else $error("input not blocked after a configuration write");

  // error results carry zero data
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == psm_pkg::StOverflow || status_o == psm_pkg::StUnderflow ||
                status_o == psm_pkg::StEmpty || status_o == psm_pkg::StBadStack))
    |-> (data_value_o == '0))
    else $error("error result with nonzero data");

  // only dump elements may be followed by more results of the same item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != psm_pkg::StDumpElem) |-> last_o)
    else $error("single result without last");

  // a result waiting without pop stays unchanged
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(data_value_o) &&
                          $stable(last_o)))
    else $error("waiting result changed");

endmodule

bind partitioned_multi_stack_top psm_checker u_checker (.*);
